// File: design/pdrc_pkg.sv
`timescale 1ns / 1ps

package pdrc_pkg;

   // Widths of the shared bit-serial multiply and divide datapath.
   localparam int MulAW  = 64;
   localparam int MulBW  = 33;
   localparam int ProdW  = MulAW + MulBW;
   localparam int NumW   = 80;
   localparam int DvsW   = 32;
   localparam int QuoW   = 48;
   localparam int CntW   = 7;

   // Last step index of a multiply and of a divide.
   localparam logic [CntW-1:0] MUL_LAST = CntW'(MulBW - 1);
   localparam logic [CntW-1:0] DIV_LAST = CntW'(NumW - 1);

   // The integral term, the derivative term and the ramp step saturate at this magnitude.
   localparam logic [QuoW-1:0] TERM_CAP = QuoW'(48'h8000_0000_0000);

   // Fixed divisors and multipliers of the millisecond time base.
   localparam logic [DvsW-1:0]  INTEG_DIV = 32'd2000;
   localparam logic [DvsW-1:0]  RAMP_DIV  = 32'd1000;
   localparam logic [MulBW-1:0] DERIV_MUL = 33'd1000;

   // Register indexes of the configuration port.
   typedef logic [2:0] csr_addr_type;
   localparam csr_addr_type REG_GAIN_P       = 3'd0;
   localparam csr_addr_type REG_GAIN_I       = 3'd1;
   localparam csr_addr_type REG_GAIN_D       = 3'd2;
   localparam csr_addr_type REG_OUTPUT_LIMIT = 3'd3;
   localparam csr_addr_type REG_OUTPUT_RAMP  = 3'd4;
   localparam csr_addr_type REG_DEAD_ZONE    = 3'd5;
   localparam csr_addr_type REG_ENABLE       = 3'd6;

   // Sequencer states.
   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_PREP     = 16'h0002,
      ST_MUL_P    = 16'h0004,
      ST_MUL_I1   = 16'h0008,
      ST_MUL_I2   = 16'h0010,
      ST_DIV_I    = 16'h0020,
      ST_MUL_D1   = 16'h0040,
      ST_MUL_D2   = 16'h0080,
      ST_DIV_D    = 16'h0100,
      ST_SUM_I    = 16'h0200,
      ST_SUM_O    = 16'h0400,
      ST_MUL_R    = 16'h0800,
      ST_RAMP_CHK = 16'h1000,
      ST_DIV_R    = 16'h2000,
      ST_RAMP_OUT = 16'h4000,
      ST_OUT      = 16'h8000
   } state_type;

endpackage

// File: design/pid_deadzone_ramp_controller.sv
`timescale 1ns / 1ps

// Discrete PID controller in signed Q16.16 with dead zone, clamp and output ramp.
// Each request word carries an error sample and the millisecond tick (or a clear
// command) and yields exactly one response word. All products but the ramp check's
// delta times 1000 go through one shared shift-add multiplier (one multiplier bit per
// cycle) and all quotients through one restoring divider (one quotient bit per cycle).
// A clear, the first step after reset and a disabled step skip the arithmetic and go
// straight to the output state. The next request word is taken once the current
// response has been written into the output register, so a stalled receiver holds
// the input.
module pid_deadzone_ramp_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  logic signed [31:0]  req_error_in,
   input  logic [31:0]         req_tick_ms,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_control_output,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_addr,
   input  logic [31:0]         csr_wdata
);

   localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
   localparam logic signed [49:0] S32_MIN = -50'sd2147483648;

   // Clamp to the symmetric limit (zero means none), then saturate to 32 bits.
   function automatic logic [31:0] clamp_sat(input logic signed [49:0] v,
                                             input logic [30:0] lim);
      logic signed [49:0] hi;
      logic signed [49:0] lo;
      logic signed [49:0] c;
      hi = $signed({19'b0, lim});
      lo = -hi;
      c  = v;
      if (lim != 31'd0) begin
         if (v > hi) begin
            c = hi;
         end else if (v < lo) begin
            c = lo;
         end
      end
      if (c > S32_MAX) begin
         c = S32_MAX;
      end else if (c < S32_MIN) begin
         c = S32_MIN;
      end
      return c[31:0];
   endfunction

   // Configuration registers.
   logic [31:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [30:0] limit_ff, ramp_ff, dz_ff;
   logic        enable_ff;

   // Sequencer and captured request.
   pdrc_pkg::state_type        st_ff, st_in;
   logic [pdrc_pkg::CntW-1:0]  cnt_ff;
   logic                       act_ff;
   logic [31:0]                err_ff, tick_ff;

   // Controller history.
   logic [31:0] last_tick_ff, prev_err_ff, prev_int_ff, prev_out_ff;

   // Per-step operands and terms.
   logic [31:0] dt_ff;
   logic        p_neg_ff, i_neg_ff, d_neg_ff, up_ff;
   logic [32:0] s_mag_ff, diff_mag_ff;
   logic [46:0] p_mag_ff;
   logic [pdrc_pkg::QuoW-1:0] i_mag_ff, d_mag_ff, step_ff;
   logic [31:0] o_ff;

   // Shared multiplier and divider.
   logic [pdrc_pkg::ProdW-1:0] prod_ff, prod_nx;
   logic [pdrc_pkg::MulAW-1:0] mcand_ff;
   logic [pdrc_pkg::NumW-1:0]  num_ff;
   logic [pdrc_pkg::DvsW-1:0]  rem_ff, dvs_ff, rem_nx;
   logic [pdrc_pkg::QuoW-1:0]  quo_ff, quo_nx, quo_cap;
   logic                       ovf_ff, ovf_nx;

   // Output register.
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   assign req_ready          = (st_ff == pdrc_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_control_output = rsp_data_ff;

   // Front-end arithmetic of a step: interval, dead zone, error sum and difference, gain magnitudes.
   logic [31:0] e_mag_raw, e_mag, e_dz, dt_raw, dt_new;
   logic        dz_hit;
   logic [32:0] s_w, diff_w, s_mag, diff_mag;
   logic [31:0] gp_mag, gi_mag, gd_mag;

   always_comb begin
      e_mag_raw = err_ff[31] ? 32'(-err_ff) : err_ff;
      dz_hit    = (dz_ff != 31'd0) && (e_mag_raw < {1'b0, dz_ff});
      e_dz      = dz_hit ? 32'd0 : err_ff;
      e_mag     = dz_hit ? 32'd0 : e_mag_raw;
      s_w       = {e_dz[31], e_dz} + {prev_err_ff[31], prev_err_ff};
      diff_w    = {e_dz[31], e_dz} - {prev_err_ff[31], prev_err_ff};
      s_mag     = s_w[32] ? 33'(-s_w) : s_w;
      diff_mag  = diff_w[32] ? 33'(-diff_w) : diff_w;
      dt_raw    = tick_ff - last_tick_ff;
      dt_new    = (dt_raw == 32'd0) ? 32'd1 : dt_raw;
      gp_mag    = gain_p_ff[31] ? 32'(-gain_p_ff) : gain_p_ff;
      gi_mag    = gain_i_ff[31] ? 32'(-gain_i_ff) : gain_i_ff;
      gd_mag    = gain_d_ff[31] ? 32'(-gain_d_ff) : gain_d_ff;
   end

   // One shift-add multiply step and one restoring divide step.
   // The partial sum stays below twice the multiplicand, so 64 bits hold it.
   logic [63:0] mul_sum;
   logic [32:0] div_r;
   logic        div_ge;

   always_comb begin
      mul_sum = {1'b0, prod_ff[95:33]} + (prod_ff[0] ? mcand_ff : 64'd0);
      prod_nx = {1'b0, mul_sum, prod_ff[32:1]};
      div_r   = {rem_ff, num_ff[pdrc_pkg::NumW-1]};
      div_ge  = div_r >= {1'b0, dvs_ff};
      rem_nx  = div_ge ? 32'(div_r - {1'b0, dvs_ff}) : div_r[31:0];
      quo_nx  = {quo_ff[pdrc_pkg::QuoW-2:0], div_ge};
      ovf_nx  = ovf_ff | quo_ff[pdrc_pkg::QuoW-1];
      quo_cap = (ovf_nx || (quo_nx > pdrc_pkg::TERM_CAP)) ? pdrc_pkg::TERM_CAP : quo_nx;
   end

   logic mul_last, div_last;
   assign mul_last = (cnt_ff == pdrc_pkg::MUL_LAST);
   assign div_last = (cnt_ff == pdrc_pkg::DIV_LAST);

   // Summing of terms and the ramp check.
   logic signed [49:0] integ_sum, out_sum, ramp_sum;
   logic [31:0]        integ_new, out_new, ramp_new;
   logic [32:0]        delta, delta_mag;
   logic [42:0]        delta_k;
   logic               ramp_hit;

   always_comb begin
      integ_sum = $signed({{18{prev_int_ff[31]}}, prev_int_ff}) +
                  $signed(i_neg_ff ? 50'(-{2'b0, i_mag_ff}) : {2'b0, i_mag_ff});
      integ_new = clamp_sat(integ_sum, limit_ff);
      out_sum   = $signed(p_neg_ff ? 50'(-{3'b0, p_mag_ff}) : {3'b0, p_mag_ff}) +
                  $signed({{18{prev_int_ff[31]}}, prev_int_ff}) +
                  $signed(d_neg_ff ? 50'(-{2'b0, d_mag_ff}) : {2'b0, d_mag_ff});
      out_new   = clamp_sat(out_sum, limit_ff);
      delta     = {o_ff[31], o_ff} - {prev_out_ff[31], prev_out_ff};
      delta_mag = delta[32] ? 33'(-delta) : delta;
      delta_k   = {10'b0, delta_mag} * 43'd1000;
      ramp_hit  = {20'b0, delta_k} > prod_ff[62:0];
      ramp_sum  = $signed({{18{prev_out_ff[31]}}, prev_out_ff}) +
                  $signed(up_ff ? {2'b0, step_ff} : 50'(-{2'b0, step_ff}));
      ramp_new  = clamp_sat(ramp_sum, 31'd0);
   end

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         pdrc_pkg::ST_IDLE: begin
            if (req_valid) st_in = pdrc_pkg::ST_PREP;
         end
         pdrc_pkg::ST_PREP: begin
            if (act_ff || (last_tick_ff == 32'd0) || !enable_ff) begin
               st_in = pdrc_pkg::ST_OUT;
            end else begin
               st_in = pdrc_pkg::ST_MUL_P;
            end
         end
         pdrc_pkg::ST_MUL_P:  if (mul_last) st_in = pdrc_pkg::ST_MUL_I1;
         pdrc_pkg::ST_MUL_I1: if (mul_last) st_in = pdrc_pkg::ST_MUL_I2;
         pdrc_pkg::ST_MUL_I2: if (mul_last) st_in = pdrc_pkg::ST_DIV_I;
         pdrc_pkg::ST_DIV_I:  if (div_last) st_in = pdrc_pkg::ST_MUL_D1;
         pdrc_pkg::ST_MUL_D1: if (mul_last) st_in = pdrc_pkg::ST_MUL_D2;
         pdrc_pkg::ST_MUL_D2: if (mul_last) st_in = pdrc_pkg::ST_DIV_D;
         pdrc_pkg::ST_DIV_D:  if (div_last) st_in = pdrc_pkg::ST_SUM_I;
         pdrc_pkg::ST_SUM_I:  st_in = pdrc_pkg::ST_SUM_O;
         pdrc_pkg::ST_SUM_O: begin
            st_in = (ramp_ff != 31'd0) ? pdrc_pkg::ST_MUL_R : pdrc_pkg::ST_OUT;
         end
         pdrc_pkg::ST_MUL_R:  if (mul_last) st_in = pdrc_pkg::ST_RAMP_CHK;
         pdrc_pkg::ST_RAMP_CHK: begin
            st_in = ramp_hit ? pdrc_pkg::ST_DIV_R : pdrc_pkg::ST_OUT;
         end
         pdrc_pkg::ST_DIV_R:  if (div_last) st_in = pdrc_pkg::ST_RAMP_OUT;
         pdrc_pkg::ST_RAMP_OUT: st_in = pdrc_pkg::ST_OUT;
         pdrc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) st_in = pdrc_pkg::ST_IDLE;
         end
         default: st_in = pdrc_pkg::ST_IDLE;
      endcase
   end

   // Operand selection for the multiply or divide about to start.
   logic                       mul_load, div_load;
   logic [pdrc_pkg::MulAW-1:0] mul_a;
   logic [pdrc_pkg::MulBW-1:0] mul_b;
   logic [pdrc_pkg::NumW-1:0]  div_n;
   logic [pdrc_pkg::DvsW-1:0]  div_d;

   always_comb begin
      mul_load = 1'b0;
      div_load = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      div_n    = '0;
      div_d    = '0;
      if (st_in != st_ff) begin
         case (st_in)
            pdrc_pkg::ST_MUL_P: begin
               mul_load = 1'b1;
               mul_a    = {32'b0, gp_mag};
               mul_b    = {1'b0, e_mag};
            end
            pdrc_pkg::ST_MUL_I1: begin
               mul_load = 1'b1;
               mul_a    = {32'b0, gi_mag};
               mul_b    = s_mag_ff;
            end
            pdrc_pkg::ST_MUL_I2: begin
               mul_load = 1'b1;
               mul_a    = prod_nx[63:0];
               mul_b    = {1'b0, dt_ff};
            end
            pdrc_pkg::ST_MUL_D1: begin
               mul_load = 1'b1;
               mul_a    = {32'b0, gd_mag};
               mul_b    = diff_mag_ff;
            end
            pdrc_pkg::ST_MUL_D2: begin
               mul_load = 1'b1;
               mul_a    = prod_nx[63:0];
               mul_b    = pdrc_pkg::DERIV_MUL;
            end
            pdrc_pkg::ST_MUL_R: begin
               mul_load = 1'b1;
               mul_a    = {33'b0, ramp_ff};
               mul_b    = {1'b0, dt_ff};
            end
            pdrc_pkg::ST_DIV_I: begin
               div_load = 1'b1;
               div_n    = prod_nx[95:16];
               div_d    = pdrc_pkg::INTEG_DIV;
            end
            pdrc_pkg::ST_DIV_D: begin
               div_load = 1'b1;
               div_n    = prod_nx[95:16];
               div_d    = dt_ff;
            end
            pdrc_pkg::ST_DIV_R: begin
               div_load = 1'b1;
               div_n    = {17'b0, prod_ff[62:0]};
               div_d    = pdrc_pkg::RAMP_DIV;
            end
            default: begin
               mul_load = 1'b0;
            end
         endcase
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         limit_ff  <= '0;
         ramp_ff   <= '0;
         dz_ff     <= '0;
         enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            pdrc_pkg::REG_GAIN_P:       gain_p_ff <= csr_wdata;
            pdrc_pkg::REG_GAIN_I:       gain_i_ff <= csr_wdata;
            pdrc_pkg::REG_GAIN_D:       gain_d_ff <= csr_wdata;
            pdrc_pkg::REG_OUTPUT_LIMIT: limit_ff  <= csr_wdata[30:0];
            pdrc_pkg::REG_OUTPUT_RAMP:  ramp_ff   <= csr_wdata[30:0];
            pdrc_pkg::REG_DEAD_ZONE:    dz_ff     <= csr_wdata[30:0];
            pdrc_pkg::REG_ENABLE:       enable_ff <= csr_wdata[0];
            default:                    enable_ff <= enable_ff;
         endcase
      end
   end

   // Sequencer, history and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= pdrc_pkg::ST_IDLE;
         last_tick_ff <= '0;
         prev_err_ff  <= '0;
         prev_int_ff  <= '0;
         prev_out_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;

         // The response word is raised out of the output state and dropped once taken.
         if (st_ff == pdrc_pkg::ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (st_ff)
            pdrc_pkg::ST_PREP: begin
               if (act_ff) begin
                  prev_err_ff <= '0;
                  prev_int_ff <= '0;
                  prev_out_ff <= '0;
               end else if (last_tick_ff == 32'd0) begin
                  last_tick_ff <= tick_ff;
               end else begin
                  last_tick_ff <= tick_ff;
                  if (!enable_ff) begin
                     prev_err_ff <= '0;
                     prev_int_ff <= '0;
                     prev_out_ff <= '0;
                  end else begin
                     prev_err_ff <= e_dz;
                  end
               end
            end
            pdrc_pkg::ST_SUM_I: prev_int_ff <= integ_new;
            pdrc_pkg::ST_SUM_O: begin
               if (ramp_ff == 31'd0) prev_out_ff <= out_new;
            end
            pdrc_pkg::ST_RAMP_CHK: begin
               if (!ramp_hit) prev_out_ff <= o_ff;
            end
            pdrc_pkg::ST_RAMP_OUT: prev_out_ff <= ramp_new;
            default: begin
               last_tick_ff <= last_tick_ff;
            end
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (st_ff == pdrc_pkg::ST_IDLE && req_valid) begin
         act_ff  <= req_action;
         err_ff  <= req_error_in;
         tick_ff <= req_tick_ms;
      end

      // Multiplier and divider: load at start, one bit per cycle after.
      if (mul_load) begin
         prod_ff  <= {64'b0, mul_b};
         mcand_ff <= mul_a;
         cnt_ff   <= '0;
      end else if (div_load) begin
         num_ff <= div_n;
         dvs_ff <= div_d;
         rem_ff <= '0;
         quo_ff <= '0;
         ovf_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         case (st_ff) inside
            pdrc_pkg::ST_MUL_P, pdrc_pkg::ST_MUL_I1, pdrc_pkg::ST_MUL_I2,
            pdrc_pkg::ST_MUL_D1, pdrc_pkg::ST_MUL_D2, pdrc_pkg::ST_MUL_R: begin
               prod_ff <= prod_nx;
               cnt_ff  <= cnt_ff + 1'b1;
            end
            pdrc_pkg::ST_DIV_I, pdrc_pkg::ST_DIV_D, pdrc_pkg::ST_DIV_R: begin
               num_ff <= {num_ff[pdrc_pkg::NumW-2:0], 1'b0};
               rem_ff <= rem_nx;
               quo_ff <= quo_nx;
               ovf_ff <= ovf_nx;
               cnt_ff <= cnt_ff + 1'b1;
            end
            default: begin
               cnt_ff <= cnt_ff;
            end
         endcase
      end

      // Per-step captures.
      case (st_ff)
         pdrc_pkg::ST_PREP: begin
            dt_ff       <= dt_new;
            s_mag_ff    <= s_mag;
            diff_mag_ff <= diff_mag;
            p_neg_ff    <= gain_p_ff[31] ^ e_dz[31];
            i_neg_ff    <= gain_i_ff[31] ^ s_w[32];
            d_neg_ff    <= gain_d_ff[31] ^ diff_w[32];
            o_ff        <= '0;
         end
         pdrc_pkg::ST_MUL_P: begin
            if (mul_last) p_mag_ff <= prod_nx[62:16];
         end
         pdrc_pkg::ST_DIV_I: begin
            if (div_last) i_mag_ff <= quo_cap;
         end
         pdrc_pkg::ST_DIV_D: begin
            if (div_last) d_mag_ff <= quo_cap;
         end
         pdrc_pkg::ST_DIV_R: begin
            if (div_last) step_ff <= quo_cap;
         end
         pdrc_pkg::ST_SUM_O:     o_ff  <= out_new;
         pdrc_pkg::ST_RAMP_CHK:  up_ff <= !delta[32];
         pdrc_pkg::ST_RAMP_OUT:  o_ff  <= ramp_new;
         pdrc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) rsp_data_ff <= o_ff;
         end
         default: begin
            up_ff <= up_ff;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   // An accepted word always starts with the decision cycle.
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (st_ff == pdrc_pkg::ST_PREP))
      else $error("accepted word did not enter decision cycle");

   // A new response appears only out of the output state.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff == pdrc_pkg::ST_OUT))
      else $error("response raised outside output state");

   // The integral and derivative terms entering the sum never exceed the term cap.
   a_term_cap: assert property (@(posedge clock) disable iff (reset)
      (st_ff == pdrc_pkg::ST_SUM_I) |->
         (i_mag_ff <= pdrc_pkg::TERM_CAP) && (d_mag_ff <= pdrc_pkg::TERM_CAP))
      else $error("integral or derivative term above cap");

   // The step counter never runs past the last divide step.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == pdrc_pkg::ST_DIV_I || st_ff == pdrc_pkg::ST_DIV_D ||
       st_ff == pdrc_pkg::ST_DIV_R) |-> (cnt_ff <= pdrc_pkg::DIV_LAST))
      else $error("divide step counter out of range");
`endif

endmodule

// File: tb/pid_deadzone_ramp_controller_tb.sv
`timescale 1ns / 1ps

module pid_deadzone_ramp_controller_tb;

   localparam bit ACT_STEP  = 1'b0;
   localparam bit ACT_CLEAR = 1'b1;
   localparam int SETTLE_CYCLES = 600;
   localparam int STALL_LIMIT = 20000;
   localparam longint unsigned MAG_CAP = 64'd1 << 47;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = 1'b0;
   logic signed [31:0] req_error_in = '0;
   logic [31:0] req_tick_ms = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_control_output;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   pid_deadzone_ramp_controller dut (.*);

   always #6 clock = ~clock;

   // Controller copy: registers and history.
   longint kp, ki, kd;
   longint unsigned lim, ramp, dzone;
   bit run_en;
   logic [31:0] seen_tick;
   longint hist_err, hist_integ, hist_out;

   logic signed [31:0] expected_outputs[$];
   int fail_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off = 0;
   int quiet_cycles = 0;
   logic [31:0] cur_tick = 32'd1;

   function automatic longint unsigned mag(longint x);
      return x < 0 ? -x : x;
   endfunction

   // floor(m * mul / div), computed exactly and capped at the term limit.
   function automatic longint unsigned scaled(longint unsigned m, longint unsigned mul,
                                              longint unsigned div);
      logic [127:0] t;
      t = ({64'd0, m} * {64'd0, mul}) / {64'd0, div};
      return (t > MAG_CAP) ? MAG_CAP : t[63:0];
   endfunction

   function automatic longint with_sign(bit neg, longint unsigned m);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp_to_limit(longint x);
      if (lim == 0) return x;
      if (x > longint'(lim)) return longint'(lim);
      if (x < -longint'(lim)) return -longint'(lim);
      return x;
   endfunction

   function automatic longint sat_word(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // One control step of the controller; updates the history.
   function automatic logic signed [31:0] control_law(bit act, logic signed [31:0] err,
                                                      logic [31:0] tick);
      longint unsigned dt, stp;
      longint e, p, s, integ, diff, d, o, delta;
      if (act == ACT_CLEAR) begin
         hist_err = 0; hist_integ = 0; hist_out = 0;
         return 0;
      end
      if (seen_tick == 0) begin
         seen_tick = tick;
         return 0;
      end
      dt = 64'(32'(tick - seen_tick));
      if (dt == 0) dt = 1;
      seen_tick = tick;
      if (!run_en) begin
         hist_err = 0; hist_integ = 0; hist_out = 0;
         return 0;
      end
      e = err;
      if (dzone > 0 && mag(e) < dzone) e = 0;
      p = with_sign((kp < 0) != (e < 0), scaled(mag(kp) * mag(e), 1, 65536));
      s = e + hist_err;
      integ = hist_integ + with_sign((ki < 0) != (s < 0),
                                     scaled(mag(ki) * mag(s), dt, 64'd2000 * 65536));
      integ = sat_word(clamp_to_limit(integ));
      diff = e - hist_err;
      d = with_sign((kd < 0) != (diff < 0), scaled(mag(kd) * mag(diff), 1000, dt * 65536));
      o = sat_word(clamp_to_limit(p + integ + d));
      // The ramp bounds the change per interval.
      if (ramp > 0) begin
         delta = o - hist_out;
         if (mag(delta) * 1000 > ramp * dt) begin
            stp = scaled(ramp, dt, 1000);
            o = sat_word(delta > 0 ? hist_out + longint'(stp) : hist_out - longint'(stp));
         end
      end
      hist_integ = integ;
      hist_out = o;
      hist_err = e;
      return o[31:0];
   endfunction

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outputs.size() == 0) begin
            $display("%0t: unexpected word, actual %0d", $realtime, rsp_control_output);
            fail_count++;
         end else begin
            if (rsp_control_output !== expected_outputs[0]) begin
               $display("%0t: control_output mismatch, expected %0d actual %0d",
                        $realtime, expected_outputs[0], rsp_control_output);
               fail_count++;
            end
            void'(expected_outputs.pop_front());
         end
      end
   end

   // Watchdog on cycles with no word moving on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[pid_deadzone_ramp_controller] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one word and wait for it to be taken; called at a falling edge.
   task automatic send_word(bit act, logic signed [31:0] err, logic [31:0] tick);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_action = act;
      req_error_in = err;
      req_tick_ms = tick;
      do @(posedge clock); while (!req_ready);
      expected_outputs.push_back(control_law(act, err, tick));
      @(negedge clock);
   endtask

   // Control step with the tick moving on by a few milliseconds.
   task automatic step_word(logic signed [31:0] err);
      cur_tick = cur_tick + $urandom_range(1, 25);
      send_word(ACT_STEP, err, cur_tick);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (expected_outputs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(pdrc_pkg::csr_addr_type addr, logic [31:0] data);
      csr_wr_en = 1'b1;
      csr_addr = addr;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (addr)
         pdrc_pkg::REG_GAIN_P: kp = longint'(signed'(data));
         pdrc_pkg::REG_GAIN_I: ki = longint'(signed'(data));
         pdrc_pkg::REG_GAIN_D: kd = longint'(signed'(data));
         pdrc_pkg::REG_OUTPUT_LIMIT: lim = data[30:0];
         pdrc_pkg::REG_OUTPUT_RAMP: ramp = data[30:0];
         pdrc_pkg::REG_DEAD_ZONE: dzone = data[30:0];
         pdrc_pkg::REG_ENABLE: run_en = data[0];
         default: ;
      endcase
   endtask

   task automatic set_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                            logic [31:0] l, logic [31:0] r, logic [31:0] z);
      wait_drained();
      write_reg(pdrc_pkg::REG_GAIN_P, p);
      write_reg(pdrc_pkg::REG_GAIN_I, i);
      write_reg(pdrc_pkg::REG_GAIN_D, d);
      write_reg(pdrc_pkg::REG_OUTPUT_LIMIT, l);
      write_reg(pdrc_pkg::REG_OUTPUT_RAMP, r);
      write_reg(pdrc_pkg::REG_DEAD_ZONE, z);
   endtask

   function automatic logic signed [31:0] rand_error();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $signed($urandom_range(0, 32'h00A0_0000)) - 32'sh0050_0000;
      endcase
   endfunction

   // First step after reset, repeated tick and the tick-zero re-arm.
   task automatic test_first_step();
      send_word(ACT_STEP, 32'sh0001_0000, 32'd100);
      send_word(ACT_STEP, 32'sh0001_0000, 32'd100);
      send_word(ACT_CLEAR, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      send_word(ACT_STEP, -32'sh0001_0000, 32'd0);
      send_word(ACT_STEP, 32'sh0002_0000, 32'd5);
      cur_tick = 32'd5;
   endtask

   // Field extremes, tick wrap, clear and a disabled step.
   task automatic test_directed();
      set_gains(32'h0002_0000, 32'h0001_8000, 32'h0000_0400, 32'h0100_0000, 0, 32'h0000_1000);
      step_word(32'sh7FFF_FFFF);
      step_word(32'sh8000_0000);
      step_word(32'sh0000_0800);
      step_word(-32'sh0000_0001);
      step_word(32'sh0000_0000);
      send_word(ACT_STEP, 32'sh0003_0000, 32'hFFFF_FFF0);
      send_word(ACT_STEP, 32'sh0003_0000, 32'h0000_0010);
      send_word(ACT_STEP, 32'sh0003_0000, 32'h0000_0010);
      send_word(ACT_CLEAR, 32'sh0001_0000, 32'h0000_0020);
      cur_tick = 32'h10;
      step_word(32'sh0004_0000);
      wait_drained();
      write_reg(pdrc_pkg::REG_ENABLE, 32'd0);
      step_word(32'sh0004_0000);
      step_word(-32'sh0004_0000);
      wait_drained();
      write_reg(pdrc_pkg::REG_ENABLE, 32'd1);
      step_word(32'sh0004_0000);
      step_word(32'sh0001_0000);
      set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h0010_0000, 0);
      step_word(32'sh7FFF_FFFF);
      step_word(32'sh8000_0000);
      step_word(32'sh1234_5678);
   endtask

   // Random words: mostly control steps, some clears and tick jumps.
   task automatic test_random(int count, int s_pct, int r_pct);
      logic [31:0] jump;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) begin
         case ($urandom_range(19))
            0: send_word(ACT_CLEAR, $urandom, $urandom);
            1: begin
               jump = $urandom;
               if ($urandom_range(4) == 0) jump = 0;
               send_word(ACT_STEP, rand_error(), jump);
               cur_tick = jump;
            end
            default: step_word(rand_error());
         endcase
      end
   endtask

   // Long receiver hold-off while words keep coming, then a full pause.
   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_off = 3000;
      repeat (8) step_word(rand_error());
      wait_drained();
      repeat (8) step_word(rand_error());
   endtask

   initial begin
      kp = 0; ki = 0; kd = 0; lim = 0; ramp = 0; dzone = 0; run_en = 1'b1;
      seen_tick = 0; hist_err = 0; hist_integ = 0; hist_out = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_first_step();
      test_directed();
      set_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 0, 0, 0);
      test_random(200, 33, 81);
      set_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 32'h0002_0000));
      test_random(200, 81, 33);
      set_gains($urandom_range(0, 32'h0008_0000), $urandom, $urandom_range(0, 32'h0000_4000),
                32'h0040_0000, 32'h0400_0000, 32'h0000_4000);
      test_random(200, 0, 0);
      test_backpressure();
      set_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                32'h7FFF_FFFF, 32'h7FFF_FFFF);
      test_random(150, 33, 81);
      set_gains($urandom, $urandom, $urandom, 0, $urandom_range(1, 32'h0100_0000),
                $urandom_range(0, 32'h0001_0000));
      test_random(150, 81, 33);
      wait_drained();
      write_reg(pdrc_pkg::REG_ENABLE, 32'd0);
      test_random(40, 0, 0);
      wait_drained();
      write_reg(pdrc_pkg::REG_ENABLE, 32'd1);
      test_random(160, 0, 0);
      wait_drained();
      if (fail_count == 0) begin
         $display("[pid_deadzone_ramp_controller] OK");
      end else begin
         $display("[pid_deadzone_ramp_controller] ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/pdrc_pkg.sv
design/pid_deadzone_ramp_controller.sv
tb/pid_deadzone_ramp_controller_tb.sv
